// ===== hw/rtl/acf_pkg.sv =====
// Shared types and constants for the allpass comb filter.
`timescale 1ns / 1ps
`default_nettype none
package acf_pkg;

  // Register map
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INVERT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DELAY  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FORM   = 2'd3;

  localparam int CFG_W       = 16;
  localparam int DELAY_CFG_W = 12;

  // Q1.15 arithmetic
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 16384;
  localparam int Q15_ONE    = 32768;
  localparam logic signed [CFG_W-1:0] GAIN_LIMIT = 16'sd32735;

  localparam logic FORM_ONE = 1'b0;
  localparam logic FORM_TWO = 1'b1;

  // Coefficients as the datapath sees them
  typedef struct packed {
    logic              form;
    logic signed [16:0] gain;
    logic signed [16:0] k;
  } coef_t;

endpackage
`default_nettype wire

// ===== hw/rtl/allpass_comb_filter.sv =====
// Top level of the Schroeder allpass comb filter.
// One item per cycle sustained while no pending result is held by a low out_ready.
// The input stage reads both delay stores at the tap; the next stage computes and writes back.
// A tap one sample back is served by write-through in the store read port.
// Reset (rst, synchronous) clears control, then a clearing pass over all MAX_DELAY slots
// (2048 by default) zeroes both stores with in_ready low; config writes still land.
`timescale 1ns / 1ps
`default_nettype none
module allpass_comb_filter #(
  parameter int MAX_DELAY    = 2048,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      signed [SAMPLE_WIDTH-1:0]      sample_out,
  input  wire logic                                cfg_wr_en,
  input  wire logic [acf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [acf_pkg::CFG_W-1:0]           cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DW = $clog2(MAX_DELAY + 1);
  localparam int LW = AW + 1;

  // configuration
  logic signed [acf_pkg::CFG_W-1:0] gain_coef;
  logic                             invert_sign;
  logic [DW-1:0]                    delay_len;
  logic                             form_select;
  logic signed [acf_pkg::CFG_W-1:0] cfg_gain;
  logic [acf_pkg::DELAY_CFG_W-1:0]  cfg_delay;

  assign cfg_gain  = $signed(cfg_data);
  assign cfg_delay = cfg_data[acf_pkg::DELAY_CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_coef   <= '0;
      invert_sign <= 1'b0;
      delay_len   <= DW'(1);
      form_select <= acf_pkg::FORM_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        acf_pkg::REG_GAIN: begin
          if (cfg_gain > acf_pkg::GAIN_LIMIT) begin
            gain_coef <= acf_pkg::GAIN_LIMIT;
          end else if (cfg_gain < -acf_pkg::GAIN_LIMIT) begin
            gain_coef <= -acf_pkg::GAIN_LIMIT;
          end else begin
            gain_coef <= cfg_gain;
          end
        end
        acf_pkg::REG_INVERT: invert_sign <= cfg_data[0];
        acf_pkg::REG_DELAY: begin
          if (cfg_delay == '0) begin
            delay_len <= DW'(1);
          end else if (32'(cfg_delay) > 32'(MAX_DELAY)) begin
            delay_len <= DW'(MAX_DELAY);
          end else begin
            delay_len <= DW'(cfg_delay);
          end
        end
        acf_pkg::REG_FORM: form_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived coefficients: effective gain and k = 1 - g^2
  logic signed [31:0] gg;
  logic signed [31:0] gg_rnd;
  logic signed [16:0] g_ext;
  acf_pkg::coef_t     coef;
  acf_pkg::coef_t     coef_next;

  assign gg     = gain_coef * gain_coef;
  assign gg_rnd = (gg + 32'(acf_pkg::ROUND_HALF)) >>> acf_pkg::FRAC_BITS;
  assign g_ext  = 17'(gain_coef);

  always_comb begin
    coef_next.form = form_select;
    coef_next.gain = invert_sign ? -g_ext : g_ext;
    coef_next.k    = $signed(17'(acf_pkg::Q15_ONE) - gg_rnd[16:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.form <= acf_pkg::FORM_ONE;
      coef.gain <= '0;
      coef.k    <= 17'(acf_pkg::Q15_ONE);
    end else begin
      coef <= coef_next;
    end
  end

  // clearing pass after reset
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(MAX_DELAY - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // handshake and pipeline control
  logic          s1_valid;
  logic          advance;
  logic          accept;
  logic [AW-1:0] wp;
  logic [AW-1:0] s1_wp;
  logic signed [SW-1:0] s1_x;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_active && (!s1_valid || advance);
  assign accept   = in_valid && in_ready;

  // read tap: wp - N modulo MAX_DELAY
  logic [LW-1:0] wp_l;
  logic [LW-1:0] n_l;
  logic [AW-1:0] rd_addr;

  assign wp_l = LW'(wp);
  assign n_l  = LW'(delay_len);

  always_comb begin
    if (wp_l >= n_l) begin
      rd_addr = AW'(wp_l - n_l);
    end else begin
      rd_addr = AW'(wp_l + LW'(MAX_DELAY) - n_l);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        wp <= (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + AW'(1);
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x  <= sample_in;
      s1_wp <= wp;
    end
  end

  // delay stores
  logic [AW-1:0] mem_waddr;
  logic          in_we;
  logic          out_we;
  logic [SW-1:0] in_wdata;
  logic [SW-1:0] out_wdata;
  logic [SW-1:0] xd_raw;
  logic [SW-1:0] od_raw;
  logic signed [SW-1:0] y;
  logic signed [SW-1:0] wr_val;

  assign mem_waddr = clr_active ? clr_addr : s1_wp;
  assign out_we    = clr_active || advance;
  assign in_we     = clr_active || (advance && (coef.form == acf_pkg::FORM_ONE));
  assign in_wdata  = clr_active ? '0 : s1_x;
  assign out_wdata = clr_active ? '0 : wr_val;

  acf_delay_mem #(
    .DEPTH (MAX_DELAY),
    .AW    (AW),
    .W     (SW)
  ) u_in_hist (
    .clk   (clk),
    .we    (in_we),
    .waddr (mem_waddr),
    .wdata (in_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (xd_raw)
  );

  acf_delay_mem #(
    .DEPTH (MAX_DELAY),
    .AW    (AW),
    .W     (SW)
  ) u_out_hist (
    .clk   (clk),
    .we    (out_we),
    .waddr (mem_waddr),
    .wdata (out_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (od_raw)
  );

  acf_arith #(
    .SW (SW)
  ) u_arith (
    .coef   (coef),
    .x      (s1_x),
    .xd     ($signed(xd_raw)),
    .od     ($signed(od_raw)),
    .y      (y),
    .wr_val (wr_val)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= y;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/acf_delay_mem.sv =====
// Delay store: one write port, one registered read port with write-through.
`timescale 1ns / 1ps
`default_nettype none
module acf_delay_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int W     = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // a read of the slot being written returns the new value
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/acf_arith.sv =====
// Allpass arithmetic for both direct forms: products, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module acf_arith #(
  parameter int SW = 16
) (
  input  wire acf_pkg::coef_t   coef,
  input  wire logic signed [SW-1:0] x,
  input  wire logic signed [SW-1:0] xd,
  input  wire logic signed [SW-1:0] od,
  output logic      signed [SW-1:0] y,
  output logic      signed [SW-1:0] wr_val
);

  localparam int AccW = SW + 20;
  localparam logic signed [AccW-1:0] SAT_MAX = {{(AccW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SAT_MIN = {{(AccW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  function automatic logic signed [SW-1:0] rnd_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    r = (acc + AccW'(acf_pkg::ROUND_HALF)) >>> acf_pkg::FRAC_BITS;
    if (r > SAT_MAX) begin
      rnd_sat = SAT_MAX[SW-1:0];
    end else if (r < SAT_MIN) begin
      rnd_sat = SAT_MIN[SW-1:0];
    end else begin
      rnd_sat = r[SW-1:0];
    end
  endfunction

  logic signed [SW:0]     diff;
  logic signed [SW:0]     a_opnd;
  logic signed [SW+17:0]  mul_a;
  logic signed [SW+16:0]  mul_b;
  logic signed [SW+16:0]  mul_c;
  logic signed [AccW-1:0] tap;
  logic signed [AccW-1:0] acc_y;
  logic signed [AccW-1:0] acc_v;
  logic signed [SW-1:0]   v;

  // form I folds its two gain products into g*(x - y[n-N])
  assign diff   = (SW+1)'(x) - (SW+1)'(od);
  assign a_opnd = (coef.form == acf_pkg::FORM_TWO) ? (SW+1)'(x) : diff;
  assign mul_a  = coef.gain * a_opnd;
  assign mul_b  = coef.k * x;
  assign mul_c  = coef.gain * od;

  assign tap   = (coef.form == acf_pkg::FORM_TWO) ? AccW'(od) : AccW'(xd);
  assign acc_y = AccW'(mul_a) + (tap <<< acf_pkg::FRAC_BITS);
  assign acc_v = AccW'(mul_b) - AccW'(mul_c);

  assign y      = rnd_sat(acc_y);
  assign v      = rnd_sat(acc_v);
  assign wr_val = (coef.form == acf_pkg::FORM_TWO) ? v : y;

endmodule
`default_nettype wire

// ===== hw/rtl/acf_checker.sv =====
// Port-level checks for the allpass comb filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module acf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] sample_out
);

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid high after reset");

  // the store clearing pass blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("in_ready high during clearing pass");

  // a new result appears only for an item taken through the input stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");

endmodule

bind allpass_comb_filter acf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_acf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);
`default_nettype wire

// ===== test/allpass_comb_filter_test.sv =====
// Self-checking testbench for the allpass comb filter: directed table, then random phases.
`timescale 1ns / 1ps
module allpass_comb_filter_test;

  localparam int DEPTH = 2048;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] sample_in;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] sample_out;
  logic cfg_wr_en;
  logic [acf_pkg::REG_IDX_W-1:0] cfg_index;
  logic [acf_pkg::CFG_W-1:0] cfg_data;

  allpass_comb_filter uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state and registers as the predictor sees them
  logic signed [15:0] x_hist [0:DEPTH-1];
  logic signed [15:0] yv_hist [0:DEPTH-1];
  logic [10:0] wr_ptr;
  logic signed [15:0] gain_reg;
  logic invert_reg;
  int delay_reg;
  logic form_reg;

  logic signed [15:0] expected_out [$];
  int fail_count = 0;
  bit send_idle;
  bit recv_idle;

  typedef struct packed {
    bit is_reg;
    logic [acf_pkg::REG_IDX_W-1:0] idx;
    logic [acf_pkg::CFG_W-1:0] data;
    logic signed [15:0] sample;
    bit typed;
    logic signed [15:0] typed_out;
  } stim_row_t;

  stim_row_t script [$];

  function automatic stim_row_t reg_row(logic [acf_pkg::REG_IDX_W-1:0] idx,
                                        logic [acf_pkg::CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t smp_row(logic signed [15:0] s, bit typed,
                                        logic signed [15:0] y);
    stim_row_t r;
    r = '0;
    r.sample = s;
    r.typed = typed;
    r.typed_out = y;
    return r;
  endfunction

  // Round to nearest Q1.15, ties towards plus infinity
  function automatic longint round_q15(longint acc);
    return (acc + longint'(acf_pkg::ROUND_HALF)) >>> acf_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic void apply_reg_write(logic [acf_pkg::REG_IDX_W-1:0] idx,
                                          logic [acf_pkg::CFG_W-1:0] data);
    int n;
    case (idx)
      acf_pkg::REG_GAIN: begin
        if ($signed(data) > acf_pkg::GAIN_LIMIT) gain_reg = acf_pkg::GAIN_LIMIT;
        else if ($signed(data) < -acf_pkg::GAIN_LIMIT) gain_reg = -acf_pkg::GAIN_LIMIT;
        else gain_reg = $signed(data);
      end
      acf_pkg::REG_INVERT: invert_reg = data[0];
      acf_pkg::REG_DELAY: begin
        n = int'(data[acf_pkg::DELAY_CFG_W-1:0]);
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        delay_reg = n;
      end
      acf_pkg::REG_FORM: form_reg = data[0];
      default: ;
    endcase
  endfunction

  // One sample through the filter; advances the delay stores
  function automatic logic signed [15:0] allpass_step(logic signed [15:0] x_s);
    longint x, g, xd, yd, k;
    logic [10:0] rd;
    logic signed [15:0] y;
    logic signed [15:0] v;
    x = longint'(x_s);
    g = invert_reg ? -longint'(gain_reg) : longint'(gain_reg);
    // a delay of the full depth reads the slot about to be overwritten
    rd = wr_ptr - delay_reg[10:0];
    yd = longint'(yv_hist[rd]);
    if (form_reg == acf_pkg::FORM_ONE) begin
      xd = longint'(x_hist[rd]);
      y = sat16(round_q15(g * x - g * yd + xd * acf_pkg::Q15_ONE));
      x_hist[wr_ptr] = x_s;
      yv_hist[wr_ptr] = y;
    end else begin
      k = acf_pkg::Q15_ONE - round_q15(g * g);
      y = sat16(round_q15(g * x + yd * acf_pkg::Q15_ONE));
      v = sat16(round_q15(k * x - g * yd));
      yv_hist[wr_ptr] = v;
    end
    wr_ptr = wr_ptr + 11'd1;
    return y;
  endfunction

  // Entered and left just after a falling edge
  task automatic send_sample(input logic signed [15:0] s, input bit typed,
                             input logic signed [15:0] typed_out);
    int gap;
    logic signed [15:0] y;
    gap = send_idle ? int'($urandom_range(0, 15)) : 0;
    cfg_wr_en <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    y = allpass_step(s);
    expected_out.push_back(typed ? typed_out : y);
    @(negedge clk);
  endtask

  task automatic drain_filter();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_out.size() != 0);
  endtask

  // Hold the write enable; the next sample lowers it
  task automatic write_reg(input logic [acf_pkg::REG_IDX_W-1:0] idx,
                           input logic [acf_pkg::CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_reg_write(idx, data);
    @(negedge clk);
  endtask

  // Result side
  initial begin
    int stall;
    logic signed [15:0] want;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_idle ? int'($urandom_range(0, 15)) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_out.size() == 0) begin
        $display("%0t sample_out: expected none, actual %0d", $time, sample_out);
        fail_count++;
      end else begin
        want = expected_out.pop_front();
        if (sample_out !== want) begin
          $display("%0t sample_out: expected %0d, actual %0d", $time, want, sample_out);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    logic signed [15:0] s;
    logic [acf_pkg::CFG_W-1:0] d;

    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      x_hist[i] = '0;
      yv_hist[i] = '0;
    end
    wr_ptr = '0;
    gain_reg = '0;
    invert_reg = 1'b0;
    delay_reg = 1;
    form_reg = acf_pkg::FORM_ONE;

    // After reset: zero gain, form I, one-sample delay, so out is the input one back
    script.push_back(smp_row(16'sh7fff, 1, 16'sh0000));
    script.push_back(smp_row(16'sh8000, 1, 16'sh7fff));
    script.push_back(smp_row(16'sh0000, 1, 16'sh8000));
    script.push_back(smp_row(16'sh0001, 1, 16'sh0000));
    // gain above the limit clamps
    script.push_back(reg_row(acf_pkg::REG_GAIN, 16'h7fff));
    script.push_back(smp_row(16'sh7fff, 0, '0));
    script.push_back(smp_row(16'sh8000, 0, '0));
    script.push_back(smp_row(16'sh8000, 0, '0));
    script.push_back(reg_row(acf_pkg::REG_INVERT, 16'h0001));
    script.push_back(smp_row(16'sh7fff, 0, '0));
    script.push_back(smp_row(16'shffff, 0, '0));
    // gain below the limit clamps
    script.push_back(reg_row(acf_pkg::REG_GAIN, 16'h8000));
    script.push_back(smp_row(16'sh8000, 0, '0));
    // zero delay acts as one
    script.push_back(reg_row(acf_pkg::REG_DELAY, 16'h0000));
    script.push_back(smp_row(16'sh3039, 0, '0));
    // over-long delay saturates to the store depth; upper data bits ignored
    script.push_back(reg_row(acf_pkg::REG_DELAY, 16'hffff));
    script.push_back(smp_row(16'sh8000, 0, '0));
    script.push_back(reg_row(acf_pkg::REG_DELAY, 16'd2048));
    script.push_back(smp_row(16'sh7fff, 0, '0));
    // form change keeps the stores
    script.push_back(reg_row(acf_pkg::REG_FORM, {15'd0, acf_pkg::FORM_TWO}));
    script.push_back(smp_row(16'sh7fff, 0, '0));
    script.push_back(smp_row(16'sh8000, 0, '0));
    script.push_back(smp_row(16'sh0000, 0, '0));
    // form II with zero gain: k is one, so out is the input one back
    script.push_back(reg_row(acf_pkg::REG_GAIN, 16'h0000));
    script.push_back(reg_row(acf_pkg::REG_INVERT, 16'h0000));
    script.push_back(reg_row(acf_pkg::REG_DELAY, 16'h0001));
    script.push_back(smp_row(16'sd100, 0, '0));
    script.push_back(smp_row(16'sh8000, 1, 16'sd100));
    script.push_back(smp_row(16'sh7fff, 1, 16'sh8000));
    script.push_back(reg_row(acf_pkg::REG_FORM, {15'd0, acf_pkg::FORM_ONE}));
    script.push_back(smp_row(16'sh0000, 0, '0));
    script.push_back(smp_row(16'sh5555, 0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        drain_filter();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_sample(script[i].sample, script[i].typed, script[i].typed_out);
      end
    end

    sent = 0;
    while (sent < 400) begin
      drain_filter();
      case ($urandom_range(0, 5))
        0: d = 16'd32735;
        1: d = 16'h8021;
        2: d = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        3: d = 16'h0000;
        default: d = 16'($urandom);
      endcase
      write_reg(acf_pkg::REG_GAIN, d);
      write_reg(acf_pkg::REG_INVERT, 16'($urandom));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: d = 16'($urandom_range(1, 8));
        5, 6: d = 16'($urandom_range(9, 300));
        7: begin
          case ($urandom_range(0, 3))
            0: d = 16'd0;
            1: d = 16'd1;
            2: d = 16'd2048;
            default: d = 16'd4095;
          endcase
        end
        8: d = 16'($urandom);
        default: d = 16'($urandom_range(2040, 2048));
      endcase
      write_reg(acf_pkg::REG_DELAY, d);
      write_reg(acf_pkg::REG_FORM, 16'($urandom));
      send_idle = $urandom_range(0, 2) != 0;
      recv_idle = $urandom_range(0, 2) != 0;
      phase_len = int'($urandom_range(20, 60));
      repeat (phase_len) begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: s = 16'($urandom);
          4: s = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
          5: s = 16'(int'($urandom_range(0, 64)) - 32);
          6: s = 16'sh0000;
          default: s = ($urandom_range(0, 1) != 0)
                       ? 16'sh7fff - 16'($urandom_range(0, 255))
                       : 16'sh8000 + 16'($urandom_range(0, 255));
        endcase
        send_sample(s, 0, '0);
        sent++;
      end
    end

    drain_filter();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && expected_out.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/acf_pkg.sv
hw/rtl/acf_delay_mem.sv
hw/rtl/acf_arith.sv
hw/rtl/allpass_comb_filter.sv
hw/rtl/acf_checker.sv
test/allpass_comb_filter_test.sv
